[hw/rtl/rgba_3x3_convolution_top_assert.svh]
// Assertion macros used by the convolution top level.
// Needs i_clk and i_rst_n in the including module.
`ifndef RGBA_3X3_CONVOLUTION_TOP_ASSERT_SVH
`define RGBA_3X3_CONVOLUTION_TOP_ASSERT_SVH
// Checks an implication on every clock edge outside reset.
`define RC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
// Checks that a signal keeps its value in the cycle after cond holds.
`define RC_HOLD(lbl, cond, sig) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> $stable(sig)) \
        else $error("value changed while held");
`endif

[hw/rtl/rc_pkg.sv]
// Types, constants and helpers for the RGBA 3x3 convolution block.
// No dependencies.
package rc_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 4096;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = 13;
    localparam int NumLanes  = 4;

    localparam logic [2:0] RegKernel  = 3'd0;
    localparam logic [2:0] RegDivisor = 3'd1;
    localparam logic [2:0] RegBias    = 3'd2;
    localparam logic [2:0] RegClamp   = 3'd3;
    localparam logic [2:0] RegChEn    = 3'd4;
    localparam logic [2:0] RegWidth   = 3'd5;
    localparam logic [2:0] RegHeight  = 3'd6;

    typedef struct packed {
        logic [53:0]       coeffs;
        logic [7:0]        divisor;
        logic signed [9:0] bias;
        logic              clamp;
    } t_lane_cfg;

    // Nine 8-bit taps of one channel, entry 0 top-left.
    typedef logic [8:0][7:0] t_taps;
endpackage

[hw/rtl/rc_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rc_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/rc_lane.sv]
// One channel lane: weighted sum, divide (skipped for a zero divisor), bias and optional clamp, step by step.
// Depends on rc_pkg.
module rc_lane import rc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_taps     i_taps,
    input  t_lane_cfg i_cfg,
    output logic      o_done,
    output logic [7:0] o_value
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_DIV, S_FIN} t_state;
    t_state r_state;
    logic signed [13:0] r_prod [9];
    logic signed [17:0] r_sum;
    logic [16:0] r_mag, r_quo;
    logic [16:0] r_rem;
    logic        r_neg;
    logic [4:0]  r_bit;
    logic [7:0]  r_val;
    logic        r_done;

    logic signed [17:0] n_sum;
    logic [17:0] n_trial;
    logic signed [18:0] n_res;
    logic signed [18:0] n_q;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 9; i++) n_sum = n_sum + 18'(r_prod[i]);
        n_trial = {r_rem, r_mag[5'd16 - r_bit]};
        // With a zero divisor the sum goes straight to the bias adder.
        if (i_cfg.divisor == 8'd0)
            n_q = 19'(r_sum);
        else
            n_q = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
        n_res = n_q + 19'(i_cfg.bias);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    for (int i = 0; i < 9; i++)
                        r_prod[i] <= $signed(i_cfg.coeffs[6*i +: 6]) *
                                     $signed({1'b0, i_taps[i]});
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sum   <= n_sum;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_neg <= r_sum[17];
                    r_mag <= r_sum[17] ? 17'(-r_sum) : 17'(r_sum);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= '0;
                    r_state <= (i_cfg.divisor == 8'd0) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    if (n_trial >= {10'd0, i_cfg.divisor}) begin
                        r_rem <= 17'(n_trial - {10'd0, i_cfg.divisor});
                        r_quo <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_rem <= n_trial[16:0];
                        r_quo <= {r_quo[15:0], 1'b0};
                    end
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd16) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_cfg.clamp && n_res < 0)
                        r_val <= 8'd0;
                    else if (i_cfg.clamp && n_res > 255)
                        r_val <= 8'd255;
                    else
                        r_val <= n_res[7:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_done  = r_done;
    assign o_value = r_val;
endmodule

[hw/rtl/rgba_3x3_convolution_top.sv]
// Top level of the RGBA 3x3 convolution: row stores, window, four lanes, merge.
// Depends on rc_pkg, rc_ram, rc_lane and the assertion header.
//
// channel | handshake          | payload
// pixel   | i_valid / o_ready  | i_in_red..i_in_alpha, i_is_filler
// result  | o_valid / i_ready  | o_out_red..o_out_alpha, o_end_of_frame
// config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time: the row stores are read, then the lanes run their
// multiply, sum, serial divide (nonzero divisor only) and bias/clamp steps,
// then a merge step. A request with a result makes it valid after the merge,
// and the next request can be taken as soon as it is valid; one without returns to idle after the read.
// The output register holds a result until taken; the next request is still
// taken and stalls in the merge only when its own result is ready.
// Reset is synchronous; it clears control state and the window and loads the default config; no clearing pass.
`include "rgba_3x3_convolution_top_assert.svh"
module rgba_3x3_convolution_top import rc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    input  logic        i_is_filler,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    output logic        o_end_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC} t_state;
    t_state r_state;

    t_lane_cfg   r_lcfg;
    logic [3:0]  r_chen;
    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [ColW-1:0] r_col;
    logic [RowW-1:0] r_row;
    logic [31:0] r_pix;
    logic [8:0][31:0] r_win;
    logic [8:0][31:0] r_save;
    logic [31:0] r_ctr;
    logic        r_eof;
    logic [3:0]  r_done;
    logic        r_ovalid;
    logic [31:0] r_out;
    logic        r_oeof;
    logic        r_start;

    logic [31:0] w_top, w_mid;
    logic [10:0] w_w;
    logic [12:0] w_h;
    logic [8:0][31:0] n_win;
    logic [8:0][31:0] w_wnext;
    logic [8:0][31:0] w_nb;
    logic [RowW-1:0] w_cy;
    logic [3:0]  w_done;
    logic [3:0][7:0] w_val;
    logic        w_acc, w_valid, w_eof, w_take, w_fin;

    assign w_acc = i_valid && o_ready;
    assign w_take = o_valid && i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_w = (r_width == 11'd0) ? 11'd1 :
                 (r_width > 11'(MaxWidth) ? 11'(MaxWidth) : r_width);
    assign w_h = (r_height == 13'd0) ? 13'd1 :
                 (r_height > 13'(MaxHeight) ? 13'(MaxHeight) : r_height);
    assign w_fin = (r_state == S_CALC) && ((r_done | w_done) == 4'hF) &&
                   (!r_ovalid || i_ready);

    rc_ram #(.Width(32), .Depth(MaxWidth)) u_upper (
        .i_clk, .i_we(r_state == S_READ), .i_waddr(r_col), .i_wdata(w_mid),
        .i_re(w_acc), .i_raddr(r_col), .o_rdata(w_top));
    rc_ram #(.Width(32), .Depth(MaxWidth)) u_middle (
        .i_clk, .i_we(r_state == S_READ), .i_waddr(r_col), .i_wdata(r_pix),
        .i_re(w_acc), .i_raddr(r_col), .o_rdata(w_mid));

    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]   = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = (r_col != '0) ? w_top : 32'd0;
        n_win[5] = (r_col != '0) ? w_mid : 32'd0;
        n_win[8] = (r_col != '0) ? r_pix : 32'd0;
        // At the start of a row the new column enters beside a cleared column; the oldest column is not cleared.
        w_wnext = n_win;
        if (r_col == '0) begin
            w_wnext[1] = '0; w_wnext[4] = '0; w_wnext[7] = '0;
            w_wnext[2] = w_top; w_wnext[5] = w_mid; w_wnext[8] = r_pix;
        end
        w_valid = (r_row >= 13'd2) || (r_row >= 13'd1 && r_col != '0);
        w_cy = (r_col != '0) ? r_row - 13'd1 : r_row - 13'd2;
        w_nb = n_win;
        if (w_cy == '0) begin
            w_nb[0] = '0; w_nb[1] = '0; w_nb[2] = '0;
        end
        if ({1'b0, w_cy} + 14'd1 >= {1'b0, w_h}) begin
            w_nb[6] = '0; w_nb[7] = '0; w_nb[8] = '0;
        end
        w_eof = (r_col == '0) && ({1'b0, r_row} >= {1'b0, w_h} + 14'd1);
    end

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        t_taps w_taps;
        always_comb
            for (int i = 0; i < 9; i++) w_taps[i] = r_win[i][8*g +: 8];
        rc_lane u_lane (.i_clk, .i_rst_n, .i_start(r_start), .i_taps(w_taps),
            .i_cfg(r_lcfg), .o_done(w_done[g]), .o_value(w_val[g]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_win    <= '0;
            r_start  <= 1'b0;
            r_done   <= '0;
            r_lcfg   <= '{coeffs: 54'd18014397603512319, divisor: 8'd1,
                          bias: 10'sd0, clamp: 1'b1};
            r_chen   <= 4'd7;
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
        end else begin
            r_start <= (r_state == S_READ) && w_valid;
            if (w_fin) r_ovalid <= 1'b1;
            else if (w_take) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    RegKernel:  r_lcfg.coeffs  <= i_cfg_data[53:0];
                    RegDivisor: r_lcfg.divisor <= i_cfg_data[7:0];
                    RegBias:    r_lcfg.bias    <= i_cfg_data[9:0];
                    RegClamp:   r_lcfg.clamp   <= i_cfg_data[0];
                    RegChEn:    r_chen   <= i_cfg_data[3:0];
                    RegWidth:   r_width  <= i_cfg_data[10:0];
                    RegHeight:  r_height <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_pix <= i_is_filler ? 32'd0 :
                             {i_in_alpha, i_in_blue, i_in_green, i_in_red};
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_eof  <= w_eof;
                    r_ctr  <= n_win[4];
                    r_save <= w_wnext;
                    // The lanes read the masked window; the real one returns at the merge.
                    if (w_valid) begin
                        r_win   <= w_nb;
                        r_done  <= '0;
                        r_state <= S_CALC;
                    end else begin
                        r_win   <= w_wnext;
                        r_state <= S_IDLE;
                    end
                    if (w_eof) begin
                        r_col <= '0; r_row <= '0;
                    end else if ({1'b0, r_col} + 11'd1 >= w_w) begin
                        r_col <= '0; r_row <= r_row + 13'd1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_CALC: begin
                    r_done <= r_done | w_done;
                    if (w_fin) begin
                        for (int ch = 0; ch < 4; ch++)
                            r_out[8*ch +: 8] <= r_chen[ch] ? w_val[ch] : r_ctr[8*ch +: 8];
                        r_oeof  <= r_eof;
                        r_win   <= r_save;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_out_red      = r_out[7:0];
    assign o_out_green    = r_out[15:8];
    assign o_out_blue     = r_out[23:16];
    assign o_out_alpha    = r_out[31:24];
    assign o_end_of_frame = r_oeof;

    `RC_ASSERT(a_no_accept_busy, (r_state != S_IDLE) |-> !o_ready)
    `RC_ASSERT(a_res_holds, (o_valid && !i_ready) |=> o_valid)
    `RC_ASSERT(a_start_calc, r_start |-> (r_state == S_CALC))
    `RC_HOLD(a_out_holds, o_valid && !i_ready, r_out)
    `RC_HOLD(a_eof_holds, o_valid && !i_ready, r_oeof)
endmodule
